[sv/planar_array_beamformer_defines.svh]
// ----------------------------------------------------------------------------
// planar_array_beamformer_defines.svh
// Assertion macros used by the beamformer checker.
// ----------------------------------------------------------------------------
`ifndef PLANAR_ARRAY_BEAMFORMER_DEFINES_SVH
`define PLANAR_ARRAY_BEAMFORMER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PAB_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("beamformer assertion failed");

// Next-cycle implication, disabled while reset is held.
`define PAB_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("beamformer assertion failed");

`endif

[sv/pab_pkg.sv]
// ----------------------------------------------------------------------------
// pab_pkg
// Sizes, codes, sine table and shared types of the planar array beamformer.
// ----------------------------------------------------------------------------
`default_nettype none

package pab_pkg;

  localparam int MAX_COLS        = 16;
  localparam int MAX_ROWS        = 16;
  localparam int SINE_TABLE_BITS = 10;

  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int NCOL_W = $clog2(MAX_COLS + 1);
  localparam int NROW_W = $clog2(MAX_ROWS + 1);
  localparam int IDXF_W = (ROW_W + NCOL_W + 1 > 8) ? ROW_W + NCOL_W + 1 : 8;

  localparam int TAPER_DEPTH = 256;
  localparam int TAPER_AW    = 8;
  localparam logic [15:0] TAPER_ONE = 16'd32768;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_DX   = 2'd2;
  localparam logic [1:0] CFG_DY   = 2'd3;

  localparam logic [0:0] FUNC_SAMPLE = 1'b0;
  localparam logic [0:0] FUNC_WEIGHT = 1'b1;

  localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
  localparam int QR_W    = SINE_TABLE_BITS - 1;

  localparam logic [63:0] POLY_C1 = 64'd1686629713;
  localparam logic [63:0] POLY_C3 = 64'd693598676;
  localparam logic [63:0] POLY_C5 = 64'd85569306;
  localparam logic [63:0] POLY_C7 = 64'd5026995;

  typedef logic [QUARTER:0][15:0] qtab_t;

  // Request from the sequencer to the taper store.
  typedef struct packed {
    logic                wr_en;
    logic [TAPER_AW-1:0] wr_addr;
    logic [15:0]         wr_data;
    logic                rd_en;
    logic [TAPER_AW-1:0] rd_addr;
  } tap_req_t;

  // Quarter-wave sine entry, odd polynomial in Q30; evaluated at elaboration.
  function automatic logic [15:0] sin_quarter(input int unsigned r);
    logic [63:0] x, x2, t, s, v;
    x  = 64'(r) << (18 - SINE_TABLE_BITS);
    x2 = (x * x) >> 16;
    t  = POLY_C5 - ((x2 * POLY_C7) >> 16);
    t  = POLY_C3 - ((x2 * t) >> 16);
    t  = POLY_C1 - ((x2 * t) >> 16);
    s  = (t * x) >> 16;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[15:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tb;
    for (int i = 0; i <= QUARTER; i++) begin
      tb[i] = sin_quarter(i);
    end
    return tb;
  endfunction

  localparam qtab_t SIN_QTAB = build_qtab();

  // Sine of a 16-bit phase in turns, signed Q1.15, by quarter-wave symmetry.
  function automatic logic signed [15:0] sin_lookup(input logic [15:0] ph);
    logic [SINE_TABLE_BITS-1:0] k;
    logic [QR_W-1:0]            r;
    logic signed [15:0]         v;
    k = ph[15 -: SINE_TABLE_BITS];
    r = {1'b0, k[SINE_TABLE_BITS-3:0]};
    if (k[SINE_TABLE_BITS-2]) begin
      r = QR_W'(QUARTER) - r;
    end
    v = signed'(SIN_QTAB[r]);
    return k[SINE_TABLE_BITS-1] ? -v : v;
  endfunction

endpackage

`default_nettype wire

[sv/pab_taper_store.sv]
// ----------------------------------------------------------------------------
// pab_taper_store
// Taper weight memory with one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pab_taper_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pab_pkg::tap_req_t  req,
  output logic [15:0]             rd_data
);
  import pab_pkg::*;

  logic [15:0]            mem [TAPER_DEPTH];
  logic [TAPER_DEPTH-1:0] vld_r;

  // Entries never written read as unity gain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= vld_r[req.rd_addr] ? mem[req.rd_addr] : TAPER_ONE;
    end
  end

endmodule

`default_nettype wire

[sv/planar_array_beamformer.sv]
// ----------------------------------------------------------------------------
// planar_array_beamformer
// Steered receive beamformer for a planar array with stored taper weights.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the in_ channel (valid/ready). With in_func = 0 a request
// carries one complex channel sample; samples come in row-major order, column
// fastest, and the first one of a frame also carries theta and phi. With
// in_func = 1 a request loads one taper weight into the weight memory.
// A weight load is written while idle and leaves the block ready. A sample
// passes through accept, memory read and trig lookup, rotation, weighting
// and accumulation; the first sample of a frame first forms the steering
// phase steps (trig lookup, direction cosines, phase steps).
// After the last element of a frame the saturated complex sum appears on the
// out_ channel. It sits in an output register, so the next frame's samples
// are taken while it waits; only the next frame's final accumulation stalls
// if the receiver has still not taken it.
// cfg_ writes set cols, rows and the element spacings; they are accepted only
// while the block is idle and belong between frames.
// Reset is synchronous: counters, accumulators and steps clear, registers
// return to a 4 by 4 array at half-wavelength spacing, and every taper weight
// reads as 1.0 until it is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module planar_array_beamformer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [0:0]         in_func,
  input  wire logic signed [15:0] in_sample_re,
  input  wire logic signed [15:0] in_sample_im,
  input  wire logic [15:0]        in_theta_turns,
  input  wire logic [15:0]        in_phi_turns,
  input  wire logic [7:0]         in_weight_index,
  input  wire logic [15:0]        in_weight_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [24:0]      out_beam_re,
  output logic signed [24:0]      out_beam_im,
  output logic                    out_saturated,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import pab_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_TRIG, ST_UXY, ST_STEP, ST_READ, ST_ROT, ST_WGT, ST_ACC
  } state_t;

  localparam logic signed [24:0] ACC_MAX = 25'sh0FFFFFF;
  localparam logic signed [24:0] ACC_MIN = -25'sh1000000;

  state_t state_r;

  logic [4:0]  cols_r, rows_r;
  logic [15:0] dx_r, dy_r;

  logic signed [15:0] re_r, im_r;
  logic [15:0]        th_r, ph_r;
  logic signed [15:0] st_r, cph_r, sph_r, c_r, s_r;
  logic signed [16:0] ux_r, uy_r;
  logic [15:0]        col_step_r, row_step_r, row_phase_r, elem_phase_r;
  logic [COL_W-1:0]   col_cnt_r;
  logic [ROW_W-1:0]   row_cnt_r;
  logic signed [24:0] acc_re_r, acc_im_r;
  logic               clip_r;
  logic signed [17:0] pre_r, pim_r;
  logic signed [19:0] wre_r, wim_r;
  logic               out_valid_r;
  logic signed [24:0] out_re_r, out_im_r;
  logic               out_sat_r;

  tap_req_t    tap_req;
  logic [15:0] tap_q;

  logic [NCOL_W-1:0] ncols;
  logic [NROW_W-1:0] nrows;
  logic              col_last, row_last, frame_first, frame_last, acc_hold;
  logic [IDXF_W-1:0] idx_full;

  logic signed [32:0] mux_c, muy_c;
  logic signed [34:0] mdx_c, mdy_c;
  logic signed [33:0] rot_re_c, rot_im_c;
  logic signed [35:0] wre_c, wim_c;
  logic signed [25:0] sum_re_c, sum_im_c;
  logic signed [24:0] sat_re_c, sat_im_c;
  logic               clip_re_c, clip_im_c;

  pab_taper_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (tap_req),
    .rd_data (tap_q)
  );

  // Sizes outside the supported range act as clamped.
  always_comb begin
    if (cols_r == '0) begin
      ncols = NCOL_W'(1);
    end else if (int'(cols_r) > MAX_COLS) begin
      ncols = NCOL_W'(MAX_COLS);
    end else begin
      ncols = NCOL_W'(cols_r);
    end
    if (rows_r == '0) begin
      nrows = NROW_W'(1);
    end else if (int'(rows_r) > MAX_ROWS) begin
      nrows = NROW_W'(MAX_ROWS);
    end else begin
      nrows = NROW_W'(rows_r);
    end
  end

  assign col_last    = (int'(col_cnt_r) + 1) >= int'(ncols);
  assign row_last    = (int'(row_cnt_r) + 1) >= int'(nrows);
  assign frame_first = (col_cnt_r == '0) && (row_cnt_r == '0);
  assign frame_last  = col_last && row_last;
  assign idx_full    = IDXF_W'(row_cnt_r) * IDXF_W'(ncols) + IDXF_W'(col_cnt_r);

  // The memory is written only in idle and read only while a sample is in
  // flight, so the two ports never touch one entry in the same cycle.
  always_comb begin
    tap_req.wr_en   = (state_r == ST_IDLE) && in_valid && (in_func == FUNC_WEIGHT);
    tap_req.wr_addr = in_weight_index;
    tap_req.wr_data = in_weight_value;
    tap_req.rd_en   = (state_r == ST_READ);
    tap_req.rd_addr = idx_full[TAPER_AW-1:0];
  end

  // Direction cosines, Q1.15 rounded.
  assign mux_c = 33'(st_r) * 33'(cph_r) + 33'sd16384;
  assign muy_c = 33'(st_r) * 33'(sph_r) + 33'sd16384;

  // Phase steps in turns with a 16-bit fraction: spacing Q4.12 times Q1.15.
  assign mdx_c = $signed({19'b0, dx_r}) * 35'(ux_r) + 35'sd1024;
  assign mdy_c = $signed({19'b0, dy_r}) * 35'(uy_r) + 35'sd1024;

  // Rotation by exp(-j*phase).
  assign rot_re_c = 34'(re_r) * 34'(c_r) + 34'(im_r) * 34'(s_r) + 34'sd16384;
  assign rot_im_c = 34'(im_r) * 34'(c_r) - 34'(re_r) * 34'(s_r) + 34'sd16384;

  // Taper weighting.
  assign wre_c = 36'(pre_r) * $signed({20'b0, tap_q}) + 36'sd16384;
  assign wim_c = 36'(pim_r) * $signed({20'b0, tap_q}) + 36'sd16384;

  // Saturating accumulation.
  always_comb begin
    sum_re_c  = 26'(acc_re_r) + 26'(wre_r);
    sum_im_c  = 26'(acc_im_r) + 26'(wim_r);
    clip_re_c = (sum_re_c > 26'(ACC_MAX)) || (sum_re_c < 26'(ACC_MIN));
    clip_im_c = (sum_im_c > 26'(ACC_MAX)) || (sum_im_c < 26'(ACC_MIN));
    if (sum_re_c > 26'(ACC_MAX)) begin
      sat_re_c = ACC_MAX;
    end else if (sum_re_c < 26'(ACC_MIN)) begin
      sat_re_c = ACC_MIN;
    end else begin
      sat_re_c = sum_re_c[24:0];
    end
    if (sum_im_c > 26'(ACC_MAX)) begin
      sat_im_c = ACC_MAX;
    end else if (sum_im_c < 26'(ACC_MIN)) begin
      sat_im_c = ACC_MIN;
    end else begin
      sat_im_c = sum_im_c[24:0];
    end
  end

  // The last accumulation waits while an unread result still holds the
  // output register.
  assign acc_hold = frame_last && out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cols_r       <= 5'd4;
      rows_r       <= 5'd4;
      dx_r         <= 16'd2048;
      dy_r         <= 16'd2048;
      col_cnt_r    <= '0;
      row_cnt_r    <= '0;
      acc_re_r     <= '0;
      acc_im_r     <= '0;
      clip_r       <= 1'b0;
      col_step_r   <= '0;
      row_step_r   <= '0;
      row_phase_r  <= '0;
      elem_phase_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_COLS: cols_r <= cfg_data[4:0];
          CFG_ROWS: rows_r <= cfg_data[4:0];
          CFG_DX:   dx_r   <= cfg_data;
          CFG_DY:   dy_r   <= cfg_data;
          default:  cols_r <= cols_r;
        endcase
      end

      // A result taken in the cycle that the next one is stored is replaced
      // below rather than cleared here.
      if (out_valid_r && out_ready && !((state_r == ST_ACC) && frame_last)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && (in_func == FUNC_SAMPLE)) begin
            re_r    <= in_sample_re;
            im_r    <= in_sample_im;
            th_r    <= in_theta_turns;
            ph_r    <= in_phi_turns;
            state_r <= frame_first ? ST_TRIG : ST_READ;
          end
        end
        ST_TRIG: begin
          st_r    <= sin_lookup(th_r);
          cph_r   <= sin_lookup(ph_r + 16'd16384);
          sph_r   <= sin_lookup(ph_r);
          state_r <= ST_UXY;
        end
        ST_UXY: begin
          ux_r    <= 17'(mux_c >>> 15);
          uy_r    <= 17'(muy_c >>> 15);
          state_r <= ST_STEP;
        end
        ST_STEP: begin
          col_step_r   <= 16'(mdx_c >>> 11);
          row_step_r   <= 16'(mdy_c >>> 11);
          row_phase_r  <= '0;
          elem_phase_r <= '0;
          acc_re_r     <= '0;
          acc_im_r     <= '0;
          clip_r       <= 1'b0;
          state_r      <= ST_READ;
        end
        ST_READ: begin
          c_r     <= sin_lookup(elem_phase_r + 16'd16384);
          s_r     <= sin_lookup(elem_phase_r);
          state_r <= ST_ROT;
        end
        ST_ROT: begin
          pre_r   <= 18'(rot_re_c >>> 15);
          pim_r   <= 18'(rot_im_c >>> 15);
          state_r <= ST_WGT;
        end
        ST_WGT: begin
          wre_r   <= 20'(wre_c >>> 15);
          wim_r   <= 20'(wim_c >>> 15);
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (!acc_hold) begin
            acc_re_r <= sat_re_c;
            acc_im_r <= sat_im_c;
            clip_r   <= clip_r | clip_re_c | clip_im_c;
            if (col_last) begin
              col_cnt_r    <= '0;
              row_phase_r  <= row_phase_r + row_step_r;
              elem_phase_r <= row_phase_r + row_step_r;
              if (row_last) begin
                row_cnt_r   <= '0;
                out_re_r    <= sat_re_c;
                out_im_r    <= sat_im_c;
                out_sat_r   <= clip_r | clip_re_c | clip_im_c;
                out_valid_r <= 1'b1;
              end else begin
                row_cnt_r <= row_cnt_r + 1'b1;
              end
            end else begin
              col_cnt_r    <= col_cnt_r + 1'b1;
              elem_phase_r <= elem_phase_r + col_step_r;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign cfg_ready     = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_beam_re   = out_re_r;
  assign out_beam_im   = out_im_r;
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

[sv/pab_checker.sv]
// ----------------------------------------------------------------------------
// pab_checker
// Port-level checks of the beamformer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "planar_array_beamformer_defines.svh"

module pab_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [0:0]         in_func,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [24:0] out_beam_re,
  input wire logic signed [24:0] out_beam_im,
  input wire logic               out_saturated
);
  import pab_pkg::*;

  // A stalled result keeps its value.
  `PAB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                  out_valid && $stable(out_beam_re) && $stable(out_beam_im) &&
                  $stable(out_saturated))

  // A sample keeps the block busy in the cycle after it is accepted.
  `PAB_ASSERT_NXT(a_sample_busy, clk, rst_n, in_valid && in_ready && (in_func == FUNC_SAMPLE), !in_ready)

  // After a weight load the block is ready again in the next cycle.
  `PAB_ASSERT_NXT(a_load_quick, clk, rst_n, in_valid && in_ready && (in_func == FUNC_WEIGHT), in_ready)

  // A new result only comes out of sample processing.
  `PAB_ASSERT_IMP(a_result_from_work, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind planar_array_beamformer pab_checker u_pab_checker (.*);

`default_nettype wire
